FILE: rtl/sbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbr_pkg;

	localparam int MAX_REFILLS = 8;
	localparam int IDX_W       = $clog2(MAX_REFILLS);
	localparam int CNT_W       = $clog2(MAX_REFILLS + 1);
	localparam int TICK_W      = 64;
	localparam int LIM_W       = 4;
	localparam int CFG_IDX_W   = 8;

	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUDGET = 8'd0,
		CFG_PERIOD = 8'd1,
		CFG_LIMIT  = 8'd2,
		CFG_START  = 8'd3
	} cfg_reg_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		tick_t   a;
		tick_t   b;
	} alu_req_t;

	// add: sum saturates, ovf is carry; sub: ovf is borrow
	typedef struct packed {
		tick_t res;
		logic  ovf;
		logic  zero;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_CH_RD,
		ST_CH_TIME,
		ST_CH_AMT,
		ST_CH_SHR,
		ST_CH_ACC,
		ST_PU_RDY,
		ST_PU_TAIL,
		ST_PU_MRG,
		ST_PU_APP,
		ST_SU_RD,
		ST_SU_TIME,
		ST_SU_ADD,
		ST_FIN
	} state_t;

	function automatic idx_t slot_add(input idx_t base, input cnt_t off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(MAX_REFILLS))
			s = s - (CNT_W+1)'(MAX_REFILLS);
		return s[IDX_W-1:0];
	endfunction

	function automatic cnt_t limit_in_use(input logic [LIM_W-1:0] lim);
		cnt_t r;
		if (lim == '0)
			r = cnt_t'(1);
		else if (32'(lim) > MAX_REFILLS)
			r = cnt_t'(MAX_REFILLS);
		else
			r = cnt_t'(lim);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sbr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sbr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/sbr_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module sbr_alu
	import sbr_pkg::*;
(
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	logic [TICK_W:0] wide;

	always_comb begin
		unique case (req.op)
			ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
			default: wide = '0;
		endcase
		rsp.ovf  = wide[TICK_W];
		rsp.zero = (wide[TICK_W-1:0] == '0);
		if (req.op == ALU_ADD && wide[TICK_W])
			rsp.res = '1;
		else
			rsp.res = wide[TICK_W-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/sporadic_budget_refill_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata: now, elapsed
// m_*      out  m_tvalid/m_tready   m_tdata: unconsumed, available, head time, head valid, fault
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request charges off refills one by one (a refill that is only shrunk also passes a shrink
// state), then sums them one by one, given the single 64-bit adder and one store read port.
// Reset and config writes to indices 0-3 rewrite entry 0 in ST_INIT; s_tready stays low then.
// The result register frees the sequencer once loaded; a stalled m_tready holds the
// sequencer in its final state and s_tready low.

module sporadic_budget_refill_queue_unit
	import sbr_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [127:0]        s_tdata,   // now[63:0], elapsed[127:64]
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [199:0]        m_tdata,   // unconsumed_ticks[63:0], available_ticks[127:64],
	                                       // head_ready_time[191:128], head_valid[192],
	                                       // fault[193], zero pad[199:194]
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [TICK_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	tick_t              budget_q, period_q, start_q;
	logic [LIM_W-1:0]   limit_q;
	logic               restart_q;
	idx_t               head_q;
	cnt_t               count_q;

	tick_t now_q, rem_q, cons_q, avail_q, ready_q, taken_q, tmp_a_q, hdt_q;
	logic  fault_q, mtime_q;
	cnt_t  i_q;
	idx_t  tail_q;

	logic [199:0] out_q;
	logic         out_valid_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic  t_we, a_we;
	idx_t  waddr, raddr;
	tick_t t_wdata, a_wdata, t_rd, a_rd;

	logic  in_acc, cfg_acc, out_load, cnt_full;
	idx_t  tail_slot;
	cnt_t  lim;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == ST_IDLE) && !restart_q;
	assign in_acc    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign lim       = limit_in_use(limit_q);
	assign cnt_full  = (count_q >= lim);
	assign tail_slot = slot_add(head_q, count_q - cnt_t'(1));

	sbr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	sbr_ram #(.WIDTH(TICK_W), .DEPTH(MAX_REFILLS)) u_time_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (waddr),
		.wdata (t_wdata),
		.raddr (raddr),
		.rdata (t_rd)
	);

	sbr_ram #(.WIDTH(TICK_W), .DEPTH(MAX_REFILLS)) u_amount_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (a_wdata),
		.raddr (raddr),
		.rdata (a_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (restart_q)
					state_d = ST_INIT;
				else if (in_acc)
					state_d = ST_CH_RD;
			end
			ST_INIT: state_d = ST_IDLE;
			ST_CH_RD: begin
				if (rem_q == '0 || count_q == '0)
					state_d = (cons_q == '0) ? ST_SU_RD : ST_PU_RDY;
				else
					state_d = ST_CH_TIME;
			end
			ST_CH_TIME: begin
				if (alu_rsp.ovf)
					state_d = (cons_q == '0) ? ST_SU_RD : ST_PU_RDY;
				else
					state_d = ST_CH_AMT;
			end
			ST_CH_AMT:  state_d = alu_rsp.ovf ? ST_CH_SHR : ST_CH_ACC;
			ST_CH_SHR:  state_d = ST_CH_ACC;
			ST_CH_ACC:  state_d = ST_CH_RD;
			ST_PU_RDY:  state_d = (count_q == '0) ? ST_PU_APP : ST_PU_TAIL;
			ST_PU_TAIL: state_d = (alu_rsp.zero || cnt_full) ? ST_PU_MRG : ST_PU_APP;
			ST_PU_MRG:  state_d = ST_SU_RD;
			ST_PU_APP:  state_d = ST_SU_RD;
			ST_SU_RD:   state_d = (i_q == count_q) ? ST_FIN : ST_SU_TIME;
			ST_SU_TIME: state_d = alu_rsp.ovf ? ST_FIN : ST_SU_ADD;
			ST_SU_ADD:  state_d = ST_SU_RD;
			ST_FIN:     state_d = out_load ? ST_IDLE : ST_FIN;
			default:    state_d = ST_IDLE;
		endcase
	end

	// store and adder control
	always_comb begin
		alu_req = '{op: ALU_ADD, a: '0, b: '0};
		t_we    = 1'b0;
		a_we    = 1'b0;
		waddr   = head_q;
		raddr   = head_q;
		t_wdata = ready_q;
		a_wdata = alu_rsp.res;
		unique case (state_q)
			ST_INIT: begin
				t_we    = 1'b1;
				a_we    = 1'b1;
				waddr   = '0;
				t_wdata = start_q;
				a_wdata = budget_q;
			end
			ST_CH_TIME: alu_req = '{op: ALU_SUB, a: now_q, b: t_rd};
			ST_CH_AMT:  alu_req = '{op: ALU_SUB, a: rem_q, b: tmp_a_q};
			ST_CH_SHR: begin
				alu_req = '{op: ALU_SUB, a: tmp_a_q, b: taken_q};
				a_we    = 1'b1;
			end
			ST_CH_ACC: alu_req = '{op: ALU_ADD, a: cons_q, b: taken_q};
			ST_PU_RDY: begin
				alu_req = '{op: ALU_ADD, a: now_q, b: period_q};
				raddr   = tail_slot;
			end
			ST_PU_TAIL: alu_req = '{op: ALU_SUB, a: ready_q, b: t_rd};
			ST_PU_MRG: begin
				alu_req = '{op: ALU_ADD, a: tmp_a_q, b: cons_q};
				a_we    = 1'b1;
				t_we    = mtime_q;
				waddr   = tail_q;
			end
			ST_PU_APP: begin
				t_we    = 1'b1;
				a_we    = 1'b1;
				waddr   = slot_add(head_q, count_q);
				a_wdata = cons_q;
			end
			ST_SU_RD:   raddr = slot_add(head_q, i_q);
			ST_SU_TIME: alu_req = '{op: ALU_SUB, a: now_q, b: t_rd};
			ST_SU_ADD:  alu_req = '{op: ALU_ADD, a: avail_q, b: tmp_a_q};
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			restart_q   <= 1'b1;
			budget_q    <= tick_t'(1);
			period_q    <= tick_t'(1);
			limit_q     <= LIM_W'(MAX_REFILLS);
			start_q     <= '0;
			head_q      <= '0;
			count_q     <= cnt_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (cfg_acc) begin
				if (cfg_index == CFG_BUDGET) begin
					budget_q  <= cfg_data;
					restart_q <= 1'b1;
				end else if (cfg_index == CFG_PERIOD) begin
					period_q  <= cfg_data;
					restart_q <= 1'b1;
				end else if (cfg_index == CFG_LIMIT) begin
					limit_q   <= cfg_data[LIM_W-1:0];
					restart_q <= 1'b1;
				end else if (cfg_index == CFG_START) begin
					start_q   <= cfg_data;
					restart_q <= 1'b1;
				end
			end else if (state_q == ST_INIT) begin
				restart_q <= 1'b0;
			end
			if (cfg_acc && cfg_index <= CFG_START) begin
				head_q  <= '0;
				count_q <= cnt_t'(1);
			end else if (state_q == ST_CH_AMT && !alu_rsp.ovf) begin
				head_q  <= slot_add(head_q, cnt_t'(1));
				count_q <= count_q - cnt_t'(1);
			end else if (state_q == ST_PU_APP) begin
				count_q <= count_q + cnt_t'(1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q   <= s_tdata[63:0];
				rem_q   <= s_tdata[127:64];
				cons_q  <= '0;
				avail_q <= '0;
				hdt_q   <= '0;
				i_q     <= '0;
				fault_q <= 1'b0;
			end
			ST_CH_TIME: tmp_a_q <= a_rd;
			ST_CH_AMT: begin
				if (alu_rsp.ovf) begin
					taken_q <= rem_q;
				end else begin
					taken_q <= tmp_a_q;
					rem_q   <= alu_rsp.res;
				end
			end
			ST_CH_SHR: rem_q <= '0;
			ST_CH_ACC: begin
				cons_q  <= alu_rsp.res;
				fault_q <= fault_q | alu_rsp.ovf;
			end
			ST_PU_RDY: begin
				ready_q <= alu_rsp.res;
				tail_q  <= tail_slot;
				fault_q <= fault_q | alu_rsp.ovf;
			end
			ST_PU_TAIL: begin
				tmp_a_q <= a_rd;
				mtime_q <= !alu_rsp.zero && !alu_rsp.ovf;
				if (!alu_rsp.zero && cnt_full && alu_rsp.ovf)
					fault_q <= 1'b1;
			end
			ST_PU_MRG: fault_q <= fault_q | alu_rsp.ovf;
			ST_SU_TIME: begin
				tmp_a_q <= a_rd;
				if (i_q == '0)
					hdt_q <= t_rd;
			end
			ST_SU_ADD: begin
				avail_q <= alu_rsp.res;
				i_q     <= i_q + cnt_t'(1);
				fault_q <= fault_q | alu_rsp.ovf;
			end
			default: ;
		endcase
		if (out_load)
			out_q <= {6'b0, fault_q, (count_q != '0), hdt_q, avail_q, rem_q};
	end

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lim)
		else $error("refill count above limit");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_CH_RD)
		else $error("accepted request did not start charging");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_acc && cfg_index <= CFG_START) |=> (count_q == cnt_t'(1) && head_q == '0
			&& restart_q))
		else $error("config write did not restart queue");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside final state");

endmodule

`default_nettype wire
